// ----- design/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define SDPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds across reset
`define SDPG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- design/sdpg_pkg.sv -----
// types, constants and a helper function of the step/dir pulse generator
package sdpg_pkg;

    localparam int POSITION_BITS = 24;
    localparam int COORD_BITS    = 24;
    localparam int HALF_BITS     = 26;
    localparam int PEND_BITS     = 27;
    localparam int NUM_AXES      = 3;
    localparam int DELTA_BITS    =
        ((POSITION_BITS > COORD_BITS) ? POSITION_BITS : COORD_BITS) + 1;
    localparam int WIDE_BITS     =
        (POSITION_BITS > COORD_BITS) ? POSITION_BITS : COORD_BITS;

    localparam logic [HALF_BITS-1:0]  HALF_MAX  = 26'h3FFFFFE;
    localparam logic [DELTA_BITS-1:0] MAG_LIMIT = DELTA_BITS'(HALF_MAX >> 1);

    typedef enum logic [2:0] {
        CMD_TICK    = 3'd0,
        CMD_REL     = 3'd1,
        CMD_ABS     = 3'd2,
        CMD_SET_POS = 3'd3,
        CMD_ENABLE  = 3'd4,
        CMD_DISABLE = 3'd5
    } sdpg_cmd_t;

    typedef struct packed {
        logic [2:0]                   command;
        logic signed [COORD_BITS-1:0] coord_x;
        logic signed [COORD_BITS-1:0] coord_y;
        logic signed [COORD_BITS-1:0] coord_z;
    } sdpg_in_t;

    typedef struct packed {
        logic [2:0]                   step_pins;
        logic [2:0]                   dir_pins;
        logic                         driver_disable;
        logic                         move_status;
        logic [PEND_BITS-1:0]         pending_half_steps;
        logic signed [COORD_BITS-1:0] position_x;
        logic signed [COORD_BITS-1:0] position_y;
        logic signed [COORD_BITS-1:0] position_z;
    } sdpg_out_t;

    // state of one axis
    typedef struct packed {
        logic [POSITION_BITS-1:0] pos;
        logic [HALF_BITS-1:0]     half;
        logic                     step;
        logic                     dir;
    } sdpg_axis_t;

    // low coordinate-width bits of a position, zero filled when narrower
    function automatic logic signed [COORD_BITS-1:0] pos_to_field(
        input logic [POSITION_BITS-1:0] p
    );
        logic [WIDE_BITS-1:0] w;
        w = WIDE_BITS'(p);
        return w[COORD_BITS-1:0];
    endfunction

endpackage

// ----- design/sdpg_axis.sv -----
// state and next-state logic of one axis
module sdpg_axis (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     adv,
    input  sdpg_pkg::sdpg_cmd_t                      cmd,
    input  logic signed [sdpg_pkg::COORD_BITS-1:0]   coord,
    input  logic                                     any_busy,
    output sdpg_pkg::sdpg_axis_t                     axis_q,
    output sdpg_pkg::sdpg_axis_t                     axis_next
);
    import sdpg_pkg::*;

    sdpg_axis_t                    axis_reg;
    logic signed [DELTA_BITS-1:0]  delta;
    logic [DELTA_BITS-1:0]         mag;
    logic [HALF_BITS-1:0]          half_load;

    // move distance at full precision
    always_comb begin
        if (cmd == CMD_ABS) begin
            delta = DELTA_BITS'(coord) - DELTA_BITS'(signed'(axis_reg.pos));
        end else begin
            delta = DELTA_BITS'(coord);
        end
        mag = delta[DELTA_BITS-1] ? DELTA_BITS'(-delta) : DELTA_BITS'(delta);
        if (mag > MAG_LIMIT) begin
            half_load = HALF_MAX;
        end else begin
            half_load = {mag[HALF_BITS-2:0], 1'b0};
        end
    end

    always_comb begin
        axis_next = axis_reg;
        case (cmd)
            CMD_TICK: begin
                if (axis_reg.half != '0) begin
                    if (axis_reg.half[0]) begin
                        // low edge: take the step
                        axis_next.step = 1'b0;
                        if (axis_reg.dir) begin
                            axis_next.pos = axis_reg.pos + 1'b1;
                        end else begin
                            axis_next.pos = axis_reg.pos - 1'b1;
                        end
                    end else begin
                        axis_next.step = 1'b1;
                    end
                    axis_next.half = axis_reg.half - 1'b1;
                end
            end
            CMD_REL, CMD_ABS: begin
                if (!any_busy && delta != '0) begin
                    axis_next.dir  = ~delta[DELTA_BITS-1];
                    axis_next.half = half_load;
                end
            end
            CMD_SET_POS: begin
                axis_next.pos = POSITION_BITS'(coord);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg <= '0;
        end else if (adv) begin
            axis_reg <= axis_next;
        end
    end

    assign axis_q = axis_reg;

endmodule

// ----- design/three_axis_step_dir_pulse_generator.sv -----
// top level of the three-axis step/dir pulse generator
//
// usage:
//   s_ channel takes one command word per cycle while s_ready is high: tick,
//   relative move, absolute move, set position, driver enable, driver disable
//   m_ channel returns one status word per command: pin levels, driver
//   disable, move rejected flag, remaining half steps and axis positions,
//   all as they stand after that command
// pipeline: a command passes the input register, then the result register;
//   throughput is one word per cycle while m_ready stays high, set by the
//   single pass of per-axis counter logic between the two registers
// stall: a word waits in the result register while m_ready is low; the
//   input register still takes one more word, then s_ready drops
// reset: synchronous, active low; positions, counters and pins clear,
//   drivers come up enabled and both channels come up empty
module three_axis_step_dir_pulse_generator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  sdpg_pkg::sdpg_in_t s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output sdpg_pkg::sdpg_out_t m_data
);
    import sdpg_pkg::*;

    // input register
    logic       in_valid_reg;
    sdpg_in_t   in_data_reg;

    // result register
    logic       m_valid_reg;
    sdpg_out_t  m_data_reg;
    sdpg_out_t  m_data_next;

    logic       drivers_off_reg;
    logic       drivers_off_next;

    logic       adv;
    logic       any_busy;
    logic       is_move;
    sdpg_cmd_t  cmd;

    sdpg_axis_t axis_q    [NUM_AXES];
    sdpg_axis_t axis_next [NUM_AXES];

    // an item moves on when the result slot is empty or being emptied
    assign adv     = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign cmd     = sdpg_cmd_t'(in_data_reg.command);
    assign is_move = (cmd == CMD_REL) || (cmd == CMD_ABS);

    // busy if any counter is still running
    assign any_busy = (axis_q[0].half != '0) || (axis_q[1].half != '0) ||
                      (axis_q[2].half != '0);

    sdpg_axis u_axis_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cmd       (cmd),
        .coord     (in_data_reg.coord_x),
        .any_busy  (any_busy),
        .axis_q    (axis_q[0]),
        .axis_next (axis_next[0])
    );

    sdpg_axis u_axis_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cmd       (cmd),
        .coord     (in_data_reg.coord_y),
        .any_busy  (any_busy),
        .axis_q    (axis_q[1]),
        .axis_next (axis_next[1])
    );

    sdpg_axis u_axis_z (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .cmd       (cmd),
        .coord     (in_data_reg.coord_z),
        .any_busy  (any_busy),
        .axis_q    (axis_q[2]),
        .axis_next (axis_next[2])
    );

    // driver chip select
    always_comb begin
        drivers_off_next = drivers_off_reg;
        case (cmd)
            CMD_REL, CMD_ABS: begin
                if (!any_busy) begin
                    drivers_off_next = 1'b0;
                end
            end
            CMD_ENABLE:  drivers_off_next = 1'b0;
            CMD_DISABLE: drivers_off_next = 1'b1;
            default: begin
            end
        endcase
    end

    // result word from the updated state
    always_comb begin
        m_data_next.step_pins      = {axis_next[2].step, axis_next[1].step,
                                      axis_next[0].step};
        m_data_next.dir_pins       = {axis_next[2].dir, axis_next[1].dir,
                                      axis_next[0].dir};
        m_data_next.driver_disable = drivers_off_next;
        m_data_next.move_status    = is_move && any_busy;
        m_data_next.pending_half_steps = PEND_BITS'(axis_next[0].half) +
                                         PEND_BITS'(axis_next[1].half) +
                                         PEND_BITS'(axis_next[2].half);
        m_data_next.position_x     = pos_to_field(axis_next[0].pos);
        m_data_next.position_y     = pos_to_field(axis_next[1].pos);
        m_data_next.position_z     = pos_to_field(axis_next[2].pos);
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
            drivers_off_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (adv) begin
                m_valid_reg     <= 1'b1;
                drivers_off_reg <= drivers_off_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/sdpg_checker.sv -----
// port-level checks of the step/dir pulse generator, bound to the top level
`include "assert_macros.svh"

module sdpg_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sdpg_pkg::sdpg_out_t m_data
);
    import sdpg_pkg::*;

    // a rejected move only happens while steps are still outstanding
    `SDPG_ASSERT(a_reject_busy, m_valid && m_data.move_status |-> m_data.pending_half_steps != '0, "move rejected with no pending half steps")

    // a word accepted while no result is waiting reaches the result side through the input and result registers
    `SDPG_ASSERT(a_result_latency, s_valid && s_ready && !m_valid |-> ##2 m_valid, "result missing two cycles after accept")

    // a stalled result holds
    `SDPG_ASSERT(a_result_hold, m_valid && !m_ready |=> m_valid && $stable(m_data), "stalled result changed")

    // no result right after reset
    `SDPG_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind three_axis_step_dir_pulse_generator sdpg_checker u_sdpg_checker (.*);

// ----- verif/three_axis_step_dir_pulse_generator_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the three-axis step/dir pulse generator
module three_axis_step_dir_pulse_generator_tb;
    import sdpg_pkg::*;

    // command codes the block does not use, sent to check that they change nothing
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam longint COORD_MAX = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    localparam longint COORD_MIN = -(longint'(1) <<< (COORD_BITS - 1));

    // two register stages plus margin for the settling wait at the end
    localparam int DRAIN_CYCLES = 20;
    // watchdog limit, far above what a correct run needs
    localparam int CYCLE_LIMIT  = 200000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    sdpg_in_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    sdpg_out_t m_data;

    // percent of cycles in which each side holds off
    int src_idle_pct  = 11;
    int sink_idle_pct = 11;

    int cycle_count    = 0;
    int mismatch_count = 0;
    int words_sent     = 0;
    int words_checked  = 0;
    int moves_taken    = 0;
    int moves_refused  = 0;

    // status words predicted for accepted commands, oldest first
    sdpg_out_t pending_status_q [$];

    // shadow copy of the generator state
    logic [POSITION_BITS-1:0] axis_pos  [NUM_AXES];
    logic [HALF_BITS-1:0]     half_left [NUM_AXES];
    logic                     neg_dir   [NUM_AXES];
    logic                     step_lvl  [NUM_AXES];
    logic                     dir_lvl   [NUM_AXES];
    logic                     drv_off;

    three_axis_step_dir_pulse_generator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side backpressure, changed on the falling edge like every other input
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // -------------------------------------------------------------------------
    // prediction
    // -------------------------------------------------------------------------

    function automatic void clear_shadow();
        int i;
        for (i = 0; i < NUM_AXES; i++) begin
            axis_pos[i]  = '0;
            half_left[i] = '0;
            neg_dir[i]   = 1'b0;
            step_lvl[i]  = 1'b0;
            dir_lvl[i]   = 1'b0;
        end
        drv_off = 1'b0;
    endfunction

    function automatic bit axes_busy();
        return (half_left[0] != 0) || (half_left[1] != 0) || (half_left[2] != 0);
    endfunction

    // load one axis for a move; a zero delta leaves the axis untouched
    function automatic void load_axis(input int i, input longint delta);
        longint mag;
        if (delta == 0)
            return;
        if (delta < 0) begin
            mag        = -delta;
            neg_dir[i] = 1'b1;
            dir_lvl[i] = 1'b0;
        end else begin
            mag        = delta;
            neg_dir[i] = 1'b0;
            dir_lvl[i] = 1'b1;
        end
        // counts that do not fit the half-step counter saturate
        if (mag > longint'(HALF_MAX >> 1))
            half_left[i] = HALF_MAX;
        else
            half_left[i] = HALF_BITS'(mag * 2);
    endfunction

    // even count raises the step pin, odd count drops it and moves the axis
    function automatic void tick_axis(input int i);
        if (half_left[i] == 0)
            return;
        if (half_left[i][0]) begin
            step_lvl[i] = 1'b0;
            axis_pos[i] = neg_dir[i] ? axis_pos[i] - 1'b1 : axis_pos[i] + 1'b1;
        end else begin
            step_lvl[i] = 1'b1;
        end
        half_left[i] = half_left[i] - 1'b1;
    endfunction

    // apply one command to the shadow state and build the status word it returns
    function automatic sdpg_out_t apply_command(input sdpg_in_t w);
        sdpg_out_t                    r;
        logic signed [COORD_BITS-1:0] c [NUM_AXES];
        logic                         refused;
        longint                       d;
        int                           i;
        c[0]    = w.coord_x;
        c[1]    = w.coord_y;
        c[2]    = w.coord_z;
        refused = 1'b0;
        case (w.command)
            CMD_TICK: begin
                for (i = 0; i < NUM_AXES; i++)
                    tick_axis(i);
            end
            CMD_REL, CMD_ABS: begin
                if (axes_busy()) begin
                    refused = 1'b1;
                end else begin
                    drv_off = 1'b0;
                    for (i = 0; i < NUM_AXES; i++) begin
                        d = longint'(c[i]);
                        // absolute target: difference at full precision, no wrap
                        if (w.command == CMD_ABS)
                            d = d - longint'($signed(axis_pos[i]));
                        load_axis(i, d);
                    end
                end
            end
            CMD_SET_POS: begin
                for (i = 0; i < NUM_AXES; i++)
                    axis_pos[i] = POSITION_BITS'(longint'(c[i]));
            end
            CMD_ENABLE: begin
                drv_off = 1'b0;
            end
            CMD_DISABLE: begin
                drv_off = 1'b1;
            end
            default: begin
            end
        endcase
        r.step_pins          = {step_lvl[2], step_lvl[1], step_lvl[0]};
        r.dir_pins           = {dir_lvl[2], dir_lvl[1], dir_lvl[0]};
        r.driver_disable     = drv_off;
        r.move_status        = refused;
        r.pending_half_steps = PEND_BITS'(half_left[0]) + PEND_BITS'(half_left[1])
                             + PEND_BITS'(half_left[2]);
        r.position_x         = axis_pos[0][COORD_BITS-1:0];
        r.position_y         = axis_pos[1][COORD_BITS-1:0];
        r.position_z         = axis_pos[2][COORD_BITS-1:0];
        return r;
    endfunction

    // -------------------------------------------------------------------------
    // checking
    // -------------------------------------------------------------------------

    function automatic void check_field(input string name, input longint want, got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    function automatic void compare_status(input sdpg_out_t want, got);
        check_field("step_pins", want.step_pins, got.step_pins);
        check_field("dir_pins", want.dir_pins, got.dir_pins);
        check_field("driver_disable", want.driver_disable, got.driver_disable);
        check_field("move_status", want.move_status, got.move_status);
        check_field("pending_half_steps", want.pending_half_steps,
                    got.pending_half_steps);
        check_field("position_x", longint'(want.position_x), longint'(got.position_x));
        check_field("position_y", longint'(want.position_y), longint'(got.position_y));
        check_field("position_z", longint'(want.position_z), longint'(got.position_z));
    endfunction

    // every status word taken from the block is matched against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status_q.size() == 0) begin
                $error("status word arrived with no command waiting for it");
                mismatch_count++;
            end else begin
                compare_status(pending_status_q.pop_front(), m_data);
                words_checked++;
            end
        end
    end

    // -------------------------------------------------------------------------
    // stimulus helpers
    // -------------------------------------------------------------------------

    function automatic sdpg_in_t make_word(input logic [2:0] cmd, input longint x, y, z);
        sdpg_in_t w;
        w.command = cmd;
        w.coord_x = x[COORD_BITS-1:0];
        w.coord_y = y[COORD_BITS-1:0];
        w.coord_z = z[COORD_BITS-1:0];
        return w;
    endfunction

    function automatic longint rand_coord();
        logic signed [COORD_BITS-1:0] v;
        v = COORD_BITS'($urandom());
        return v;
    endfunction

    // mostly short moves, some zero, now and then a longer one
    function automatic longint small_delta();
        int r;
        r = $urandom_range(63);
        if (r < 12)
            return 0;
        if (r == 63)
            return longint'($urandom_range(120)) - 60;
        return longint'($urandom_range(12)) - 6;
    endfunction

    // absolute target a short way from the current position, kept inside the range
    function automatic longint near_target(input int i);
        longint here, off, t;
        here = longint'($signed(axis_pos[i]));
        off  = small_delta();
        t    = here + off;
        if (t > COORD_MAX || t < COORD_MIN)
            t = here - off;
        return t;
    endfunction

    // present one word, hold it until taken, then record its prediction
    task automatic send_word(input sdpg_in_t w);
        sdpg_out_t want;
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        want = apply_command(w);
        pending_status_q.push_back(want);
        words_sent++;
        if (w.command == CMD_REL || w.command == CMD_ABS) begin
            if (want.move_status)
                moves_refused++;
            else
                moves_taken++;
        end
    endtask

    // tick until every axis has finished; the ignored coordinates carry noise
    task automatic tick_to_idle();
        while (axes_busy())
            send_word(make_word(CMD_TICK, rand_coord(), rand_coord(), rand_coord()));
    endtask

    // stop sending and wait for every outstanding status word
    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_status_q.size() != 0)
            @(posedge aclk);
    endtask

    // -------------------------------------------------------------------------
    // tests
    // -------------------------------------------------------------------------

    // commands on an idle block: idle tick, unused codes, driver enable and disable
    task automatic test_idle_commands();
        send_word(make_word(CMD_TICK, COORD_MAX, COORD_MIN, -1));
        send_word(make_word(CMD_SPARE_6, COORD_MIN, COORD_MAX, 1));
        send_word(make_word(CMD_SPARE_7, -1, -1, -1));
        send_word(make_word(CMD_DISABLE, 0, 0, 0));
        send_word(make_word(CMD_SPARE_7, 5, 6, 7));
        send_word(make_word(CMD_ENABLE, COORD_MAX, COORD_MAX, COORD_MAX));
    endtask

    // positions at the extremes, then one step each way so they wrap
    task automatic test_position_wrap();
        send_word(make_word(CMD_SET_POS, COORD_MAX, COORD_MIN, 0));
        send_word(make_word(CMD_DISABLE, 0, 0, 0));
        // z has a zero delta: it keeps its direction and stays idle
        send_word(make_word(CMD_REL, 1, -1, 0));
        // moves while busy are refused, extremes included
        send_word(make_word(CMD_REL, COORD_MIN, COORD_MAX, -1));
        send_word(make_word(CMD_ABS, COORD_MAX, COORD_MIN, 1));
        tick_to_idle();
        // all-zero move is still accepted and turns the drivers back on
        send_word(make_word(CMD_DISABLE, 0, 0, 0));
        send_word(make_word(CMD_REL, 0, 0, 0));
    endtask

    // absolute moves from the extremes, set position while the axes run
    task automatic test_absolute_moves();
        send_word(make_word(CMD_ABS, COORD_MIN + 3, COORD_MAX - 2, -1));
        send_word(make_word(CMD_TICK, 0, 0, 0));
        send_word(make_word(CMD_TICK, 0, 0, 0));
        send_word(make_word(CMD_SET_POS, 100, -100, 5));
        send_word(make_word(CMD_REL, 1, 1, 1));
        tick_to_idle();
        // target equal to the current position: nothing to move
        send_word(make_word(CMD_ABS, longint'($signed(axis_pos[0])),
                            longint'($signed(axis_pos[1])),
                            longint'($signed(axis_pos[2]))));
        tick_to_idle();
    endtask

    // weighted random commands; while busy mostly ticks, while idle mostly moves
    task automatic test_random_traffic(input int count);
        int sel;
        repeat (count) begin
            sel = $urandom_range(99);
            if (axes_busy()) begin
                if (sel < 70)
                    send_word(make_word(CMD_TICK, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 76)
                    send_word(make_word(CMD_REL, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 82)
                    send_word(make_word(CMD_ABS, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 89)
                    send_word(make_word(CMD_SET_POS, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 93)
                    send_word(make_word(CMD_ENABLE, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 97)
                    send_word(make_word(CMD_DISABLE, rand_coord(), rand_coord(), rand_coord()));
                else
                    send_word(make_word(sel[0] ? CMD_SPARE_7 : CMD_SPARE_6,
                                        rand_coord(), rand_coord(), rand_coord()));
            end else begin
                if (sel < 12)
                    send_word(make_word(CMD_TICK, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 48)
                    send_word(make_word(CMD_REL, small_delta(), small_delta(), small_delta()));
                else if (sel < 74)
                    send_word(make_word(CMD_ABS, near_target(0), near_target(1),
                                        near_target(2)));
                else if (sel < 80)
                    // near the ends of the range so later moves wrap
                    send_word(make_word(CMD_SET_POS, COORD_MAX - $urandom_range(3),
                                        COORD_MIN + $urandom_range(3), rand_coord()));
                else if (sel < 88)
                    send_word(make_word(CMD_SET_POS, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 92)
                    send_word(make_word(CMD_ENABLE, rand_coord(), rand_coord(), rand_coord()));
                else if (sel < 97)
                    send_word(make_word(CMD_DISABLE, rand_coord(), rand_coord(), rand_coord()));
                else
                    send_word(make_word(sel[0] ? CMD_SPARE_7 : CMD_SPARE_6,
                                        rand_coord(), rand_coord(), rand_coord()));
            end
        end
    endtask

    // back to back traffic with neither side holding off
    task automatic test_steady_stream(input int count);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_traffic(count);
        hold_until_drained();
        src_idle_pct  = 11;
        sink_idle_pct = 11;
    endtask

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        clear_shadow();
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_commands();
        test_position_wrap();
        test_absolute_moves();
        test_random_traffic(350);
        // sender waits for the block to empty before going on
        hold_until_drained();
        test_steady_stream(200);
        test_random_traffic(300);
        tick_to_idle();

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (pending_status_q.size() != 0) begin
            $error("%0d status words never arrived", pending_status_q.size());
            mismatch_count++;
        end

        $display("run covered %0d command words and %0d checked status words",
                 words_sent, words_checked);
        $display("moves taken %0d, moves refused while axes busy %0d",
                 moves_taken, moves_refused);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+design
design/sdpg_pkg.sv
design/sdpg_axis.sv
design/three_axis_step_dir_pulse_generator.sv
design/sdpg_checker.sv
verif/three_axis_step_dir_pulse_generator_tb.sv
